FILE: sv/smsrng_pkg.sv
// Shared constants, controller states and command/status types for the shuffled generator.
`default_nettype none

package smsrng_pkg;

    localparam int DEF_TABLE_ENTRIES = 32;
    localparam int DEF_WARMUP_STEPS  = 8;

    localparam logic [14:0] LCG_MUL       = 15'd16807;
    localparam logic [30:0] LCG_MOD       = 31'h7FFF_FFFF;
    localparam logic [30:0] CAP_THRESHOLD = 31'd2147483390;

    localparam int SEED_W = 32;
    localparam int VAL_W  = 31;
    localparam int PROD_W = 47;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_FILL_MUL,
        ST_FILL_MOD,
        ST_DIV_INIT,
        ST_DIV,
        ST_DRAW_MUL,
        ST_DRAW_MOD,
        ST_READ,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic mod;
        logic fill_we;
        logic set_last;
        logic div_init;
        logic div_step;
        logic seed_store;
        logic rd;
        logic wr;
    } cmd_t;

    typedef struct packed {
        logic reinit;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

FILE: sv/smsrng_ctrl.sv
// Sequencing state machine for seeding, table fill, slot division and draw.
`default_nettype none

module smsrng_ctrl #(
    parameter int TABLE_ENTRIES = smsrng_pkg::DEF_TABLE_ENTRIES,
    parameter int WARMUP_STEPS  = smsrng_pkg::DEF_WARMUP_STEPS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire smsrng_pkg::status_t          status,
    output smsrng_pkg::cmd_t                  cmd,
    output logic [$clog2(TABLE_ENTRIES)-1:0]  fill_idx
);
    import smsrng_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int STEPS = TABLE_ENTRIES + WARMUP_STEPS;
    localparam int CNT_W = $clog2(STEPS);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              in_table;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Warm-up steps run with the counter at or above the table size.
    assign in_table = ({1'b0, cnt_reg} < (CNT_W + 1)'(TABLE_ENTRIES));
    assign fill_idx = cnt_reg[IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (status.reinit)
                begin
                    cnt_next   = CNT_W'(STEPS - 1);
                    state_next = ST_FILL_MUL;
                end
                else
                begin
                    state_next = ST_DIV_INIT;
                end
            end
            ST_FILL_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_FILL_MOD;
            end
            ST_FILL_MOD:
            begin
                cmd.mod     = 1'b1;
                cmd.fill_we = in_table;
                if (cnt_reg == '0)
                begin
                    cmd.set_last = 1'b1;
                    state_next   = ST_DIV_INIT;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_FILL_MUL;
                end
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = ST_DRAW_MUL;
            end
            ST_DRAW_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DRAW_MOD;
            end
            ST_DRAW_MOD:
            begin
                cmd.mod        = 1'b1;
                cmd.seed_store = 1'b1;
                state_next     = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // Hold until the output register can take the result.
                if (!status.out_busy)
                begin
                    cmd.wr     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_fill_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL_MUL || state_reg == ST_FILL_MOD)
            |-> ({1'b0, cnt_reg} < (CNT_W + 1)'(STEPS)))
        else $error("fill counter out of range");
    a_div_follows_init: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_init |=> (state_reg == ST_DIV))
        else $error("slot quotient step did not follow the product step");
    a_wr_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> !status.out_busy)
        else $error("result written while output register is blocked");
    a_write_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle after write");
`endif

endmodule

`default_nettype wire

FILE: sv/smsrng_dp.sv
// Datapath: seed and output registers, modular multiplier, slot divider and shuffle memory.
`default_nettype none

module smsrng_dp #(
    parameter int TABLE_ENTRIES = smsrng_pkg::DEF_TABLE_ENTRIES
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire smsrng_pkg::cmd_t                    cmd,
    input  wire logic [$clog2(TABLE_ENTRIES)-1:0]    fill_idx,
    output smsrng_pkg::status_t                      status,
    input  wire logic                                action,
    input  wire logic signed [31:0]                  seed_value,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_stall,
    output logic [30:0]                              random_value,
    output logic                                     capped
);
    import smsrng_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [31:0] SLOT_DIV =
        32'((64'(LCG_MOD) - 64'd1) / 64'(TABLE_ENTRIES) + 64'd1);
    // Rounded-up reciprocal: exact quotient by SLOT_DIV for every 31-bit dividend.
    localparam int SLOT_SHIFT = VAL_W + $clog2(SLOT_DIV);
    localparam logic [31:0] SLOT_RECIP =
        32'(((64'd1 << SLOT_SHIFT) + 64'(SLOT_DIV) - 64'd1) / 64'(SLOT_DIV));
    localparam int SPROD_W = VAL_W + 32;

    logic signed [SEED_W-1:0] seed_reg;
    logic [VAL_W-1:0]         last_reg;
    logic                     reinit_reg;
    logic [SEED_W-1:0]        s_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [SPROD_W-1:0]       slot_prod_reg;
    logic [IDX_W-1:0]         q_reg;
    logic [VAL_W-1:0]         rd_reg;
    logic                     out_valid_reg;
    logic [VAL_W-1:0]         out_val_reg;
    logic                     out_cap_reg;
    logic [VAL_W-1:0]         shuffle_mem [TABLE_ENTRIES];

    logic signed [SEED_W-1:0] eff_seed;
    logic                     eff_nonpos;
    logic [SEED_W-1:0]        eff_mag;
    logic [SEED_W-1:0]        s_init;
    logic [31:0]              fold_sum;
    logic [VAL_W-1:0]         mod_res;
    logic [IDX_W-1:0]         slot;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_wa;
    logic [VAL_W-1:0]         mem_wd;

    // Seed selection: a load replaces the stored seed before the draw.
    // A reinitialization starts from the negated seed, or from 1 when it is not negative.
    assign eff_seed   = action ? seed_value : seed_reg;
    assign eff_nonpos = eff_seed[31] || (eff_seed == '0);
    assign eff_mag    = ~eff_seed + 32'd1;
    assign s_init     = eff_seed[31] ? eff_mag
                      : ((eff_nonpos || (last_reg == '0)) ? 32'd1 : eff_seed);

    // Reduce mod 2^31-1 by folding the high part onto the low part.
    assign fold_sum = 32'(prod_reg[30:0]) + 32'(prod_reg[PROD_W-1:31]);
    assign mod_res  = (fold_sum >= 32'(LCG_MOD)) ? 31'(fold_sum - 32'(LCG_MOD))
                                                 : fold_sum[30:0];

    assign slot   = ({1'b0, q_reg} > (IDX_W + 1)'(TABLE_ENTRIES - 1))
                  ? IDX_W'(TABLE_ENTRIES - 1) : q_reg;

    assign mem_we = cmd.fill_we || cmd.wr;
    assign mem_wa = cmd.fill_we ? fill_idx : slot;
    assign mem_wd = cmd.fill_we ? mod_res : s_reg[VAL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            last_reg      <= '0;
            reinit_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                seed_reg   <= eff_seed;
                reinit_reg <= eff_nonpos || (last_reg == '0);
            end
            else if (cmd.seed_store)
            begin
                seed_reg <= {1'b0, mod_res};
            end
            if (cmd.set_last)
            begin
                last_reg <= mod_res;
            end
            else if (cmd.wr)
            begin
                last_reg <= rd_reg;
            end
            if (cmd.wr)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            s_reg <= s_init;
        end
        else if (cmd.mod)
        begin
            s_reg <= {1'b0, mod_res};
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(s_reg) * PROD_W'(LCG_MUL);
        end
        if (cmd.div_init)
        begin
            slot_prod_reg <= SPROD_W'(last_reg) * SPROD_W'(SLOT_RECIP);
        end
        if (cmd.div_step)
        begin
            q_reg <= IDX_W'(slot_prod_reg >> SLOT_SHIFT);
        end
        if (cmd.wr)
        begin
            out_val_reg <= rd_reg;
            out_cap_reg <= (rd_reg >= CAP_THRESHOLD);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            shuffle_mem[mem_wa] <= mem_wd;
        end
        if (cmd.rd)
        begin
            rd_reg <= shuffle_mem[slot];
        end
    end

    assign status.reinit   = reinit_reg;
    assign status.out_busy = out_valid_reg && rsp_stall;
    assign rsp_valid       = out_valid_reg;
    assign random_value    = out_val_reg;
    assign capped          = out_cap_reg;

`ifndef SYNTHESIS
    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.fill_we && cmd.wr))
        else $error("fill and draw write collide on the shuffle memory");
    a_mod_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mod |=> (s_reg < 32'(LCG_MOD)))
        else $error("generator value not reduced below the modulus");
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> ({1'b0, q_reg} < (IDX_W + 1)'(TABLE_ENTRIES)))
        else $error("slot quotient beyond table");
    a_fill_feeds_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_last |-> (cmd.fill_we && fill_idx == '0))
        else $error("last output not taken from entry zero");
`endif

endmodule

`default_nettype wire

FILE: sv/shuffled_minimal_standard_rng.sv
// Top level of the shuffled minimal-standard generator (Lehmer 16807 mod 2^31-1, shuffle table).
// Draw: without reinitialization a request steps through start, divide, draw, read and write
// before rsp_valid rises, for any TABLE_ENTRIES. The next request is taken only once the
// controller is back in idle, so requests are not overlapped; a reinitialization adds the
// warm-up and fill steps, and a stalled result holds the write.
// Reset (rst_n, async, low) clears seed and last output, so the first request refills the table.
`default_nettype none

module shuffled_minimal_standard_rng #(
    parameter int TABLE_ENTRIES = smsrng_pkg::DEF_TABLE_ENTRIES,
    parameter int WARMUP_STEPS  = smsrng_pkg::DEF_WARMUP_STEPS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // request channel
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic               action,
    input  wire logic signed [31:0] seed_value,
    // result channel
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output logic [30:0]             random_value,
    output logic                    capped
);
    import smsrng_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    // Command and status bundles between the sequencer and the datapath.
    cmd_t             cmd;
    status_t          status;
    logic [IDX_W-1:0] fill_idx;

    // The sequencer walks each request through:
    //   start    - decide on reinitialization (seed zero/negative, or table never filled)
    //   fill     - warm-up steps, then fill the table from the top entry down to entry 0
    //   divide   - multiply the last output by the slot reciprocal, then take the quotient
    //   draw     - advance the generator once and store the new seed
    //   read     - fetch the old slot content
    //   write    - put the new value in the slot and move the old one to the output register
    // The output register decouples the two channels: a result may wait for its transfer
    // while the next request is already being worked on.
    smsrng_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .WARMUP_STEPS  (WARMUP_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd),
        .fill_idx  (fill_idx)
    );

    // Datapath holds the seed, last output, the shuffle memory, the multiply and
    // fold-based reduction mod 2^31-1, the reciprocal slot division and the output register.
    smsrng_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .fill_idx     (fill_idx),
        .status       (status),
        .action       (action),
        .seed_value   (seed_value),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .random_value (random_value),
        .capped       (capped)
    );

endmodule

`default_nettype wire
